// ----- rtl/cstp_pkg.sv -----
// shared types and constants of the call stack time profiler
package cstp_pkg;

  localparam int FUNC_COUNT_DEF  = 256;
  localparam int STACK_DEPTH_DEF = 32;
  localparam int TIME_BITS_DEF   = 48;

  localparam int ID_W    = 8;
  localparam int LANG_W  = 4;
  localparam int TS_W    = 48;
  localparam int ACC_W   = 56;
  localparam int CNT_W   = 32;
  localparam int LVL_W   = 6;
  localparam int ACT_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [ACT_W-1:0] ACT_ENTER      = 3'd0;
  localparam logic [ACT_W-1:0] ACT_EXIT       = 3'd1;
  localparam logic [ACT_W-1:0] ACT_READ       = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ_CLEAR = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CNT_CLEAR  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_CLEAR_ALL  = 3'd5;

  localparam logic [STAT_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd3;

  localparam logic [0:0] REG_TRACE_ENABLE = 1'd0;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture input item
    logic exec;     // memories read data valid, compute and write back
    logic out_set;  // result register loaded
    logic out_clr;  // result taken
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ----- rtl/cstp_if.sv -----
// valid/ready channel interfaces of the profiler
interface cstp_in_if;
  logic                         valid;
  logic                         ready;
  logic [cstp_pkg::ACT_W-1:0]   action;
  logic [cstp_pkg::ID_W-1:0]    func_id;
  logic [cstp_pkg::LANG_W-1:0]  language_id;
  logic [cstp_pkg::TS_W-1:0]    timestamp;
  modport source (output valid, action, func_id, language_id, timestamp, input ready);
  modport sink (input valid, action, func_id, language_id, timestamp, output ready);
endinterface

interface cstp_out_if;
  logic                         valid;
  logic                         ready;
  logic [cstp_pkg::STAT_W-1:0]  status;
  logic                         entry_present;
  logic [cstp_pkg::CNT_W-1:0]   calls_total;
  logic [cstp_pkg::ACC_W-1:0]   inclusive_total;
  logic [cstp_pkg::ACC_W-1:0]   self_total;
  logic [cstp_pkg::LANG_W-1:0]  entry_language;
  logic [cstp_pkg::CNT_W-1:0]   total_count;
  logic [cstp_pkg::CNT_W-1:0]   dropped_count;
  logic [cstp_pkg::LVL_W-1:0]   stack_level;
  modport source (output valid, status, entry_present, calls_total, inclusive_total,
                  self_total, entry_language, total_count, dropped_count, stack_level,
                  input ready);
  modport sink (input valid, status, entry_present, calls_total, inclusive_total,
                self_total, entry_language, total_count, dropped_count, stack_level,
                output ready);
endinterface

// ----- rtl/call_stack_time_profiler_core.sv -----
// top level of the call stack time profiler
// channel | dir | handshake     | payload
// in      | in  | valid/ready   | action, func_id, language_id, timestamp
// out     | out | valid/ready   | status, entry and counter fields, stack_level
// cfg     | in  | apb, pready=1 | trace_enable at address 0
// each item passes through capture, registered memory read, compute and write back
// of stack and table, then the result register, where it waits for the output.
// one item in flight; the next item is taken once the result has been taken.
// reset is synchronous; no clearing pass is needed, valid bits clear at once.
module call_stack_time_profiler_core #(
  parameter int FUNC_COUNT  = cstp_pkg::FUNC_COUNT_DEF,
  parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
  parameter int TIME_BITS   = cstp_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cstp_in_if.sink     in_ch,
  cstp_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cstp_pkg::cmd_t cmd;
  cstp_pkg::sts_t sts;
  logic trace_enable;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable <= 1'b0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      trace_enable <= pwdata[0];
    end
  end
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {31'd0, trace_enable} : 32'd0;

  cstp_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_ready(out_ch.ready),
    .sts, .cmd
  );

  cstp_dp #(.FUNC_COUNT(FUNC_COUNT), .STACK_DEPTH(STACK_DEPTH), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst, .cmd, .sts, .trace_enable,
    .in_action      (in_ch.action),
    .in_func_id     (in_ch.func_id),
    .in_language_id (in_ch.language_id),
    .in_timestamp   (in_ch.timestamp),
    .status         (out_ch.status),
    .entry_present  (out_ch.entry_present),
    .calls_total    (out_ch.calls_total),
    .inclusive_total(out_ch.inclusive_total),
    .self_total     (out_ch.self_total),
    .entry_language (out_ch.entry_language),
    .total_count    (out_ch.total_count),
    .dropped_count  (out_ch.dropped_count),
    .stack_level    (out_ch.stack_level)
  );

  assign out_ch.valid = sts.out_full;

endmodule

// ----- rtl/cstp_ctrl.sv -----
// sequencing state machine of the profiler
module cstp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  input  cstp_pkg::sts_t    sts,
  output cstp_pkg::cmd_t    cmd
);

  cstp_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cstp_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cstp_pkg::S_IDLE: begin
        if (in_valid) state_next = cstp_pkg::S_READ;
      end
      cstp_pkg::S_READ:  state_next = cstp_pkg::S_WRITE;
      cstp_pkg::S_WRITE: state_next = cstp_pkg::S_OUT;
      cstp_pkg::S_OUT: begin
        if (out_ready) state_next = cstp_pkg::S_IDLE;
      end
      default: state_next = cstp_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      cstp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      // memories are read at the end of this cycle
      cstp_pkg::S_READ: ;
      cstp_pkg::S_WRITE: begin
        cmd.exec    = 1'b1;
        cmd.out_set = 1'b1;
      end
      cstp_pkg::S_OUT:   cmd.out_clr = out_ready && sts.out_full;
      default: ;
    endcase
  end

endmodule

// ----- rtl/cstp_dp.sv -----
// frame stack, statistics table and counters of the profiler
module cstp_dp #(
  parameter int FUNC_COUNT  = cstp_pkg::FUNC_COUNT_DEF,
  parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
  parameter int TIME_BITS   = cstp_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cstp_pkg::cmd_t                cmd,
  output cstp_pkg::sts_t                sts,
  input  logic                          trace_enable,
  input  logic [cstp_pkg::ACT_W-1:0]    in_action,
  input  logic [cstp_pkg::ID_W-1:0]     in_func_id,
  input  logic [cstp_pkg::LANG_W-1:0]   in_language_id,
  input  logic [cstp_pkg::TS_W-1:0]     in_timestamp,
  output logic [cstp_pkg::STAT_W-1:0]   status,
  output logic                          entry_present,
  output logic [cstp_pkg::CNT_W-1:0]    calls_total,
  output logic [cstp_pkg::ACC_W-1:0]    inclusive_total,
  output logic [cstp_pkg::ACC_W-1:0]    self_total,
  output logic [cstp_pkg::LANG_W-1:0]   entry_language,
  output logic [cstp_pkg::CNT_W-1:0]    total_count,
  output logic [cstp_pkg::CNT_W-1:0]    dropped_count,
  output logic [cstp_pkg::LVL_W-1:0]    stack_level
);

  localparam int SA_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LV_W = $clog2(STACK_DEPTH + 1);
  localparam int FA_W = (FUNC_COUNT > 1) ? $clog2(FUNC_COUNT) : 1;
  localparam int ACC_W = cstp_pkg::ACC_W;
  localparam int CNT_W = cstp_pkg::CNT_W;
  localparam int ID_W = cstp_pkg::ID_W;
  localparam int LANG_W = cstp_pkg::LANG_W;
  localparam int FR_W = ID_W + LANG_W + TIME_BITS;
  localparam int EN_W = CNT_W + 2 * ACC_W + LANG_W;
  localparam logic [ACC_W-1:0] MAX_ACC = '1;
  localparam logic [CNT_W-1:0] MAX_CNT = '1;

  // stack memories: frame header and child sums in separate arrays
  logic [FR_W-1:0]   frame_mem [STACK_DEPTH];
  logic [ACC_W-1:0]  kids_mem  [STACK_DEPTH];
  logic [EN_W-1:0]   entry_mem [FUNC_COUNT];
  logic [FUNC_COUNT-1:0] entry_valid;

  logic [LV_W-1:0]   level;
  logic [CNT_W-1:0]  enter_events, drop_events;

  // captured item
  logic [cstp_pkg::ACT_W-1:0]  act;
  logic [ID_W-1:0]             fid;
  logic [LANG_W-1:0]           lang;
  logic [TIME_BITS-1:0]        ts;

  // read data
  logic [FR_W-1:0]   top_rd;
  logic [ACC_W-1:0]  kids_rd, parent_rd;
  logic [EN_W-1:0]   ent_rd;

  logic [FA_W-1:0]   slot;
  logic [SA_W-1:0]   top_a, par_a;
  logic              out_full;

  assign slot  = FA_W'(fid % FUNC_COUNT);
  assign top_a = SA_W'(level - LV_W'(1));
  assign par_a = SA_W'(level - LV_W'(2));

  // capture item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act  <= in_action;
      fid  <= in_func_id;
      lang <= in_language_id;
      ts   <= in_timestamp[TIME_BITS-1:0];
    end
  end

  // memory reads, registered in the cycle after capture
  always_ff @(posedge clk) begin
    top_rd    <= frame_mem[top_a];
    kids_rd   <= kids_mem[top_a];
    parent_rd <= kids_mem[par_a];
    ent_rd    <= entry_mem[slot];
  end

  // decode
  logic is_trace, ign, do_push, full, do_exit, empty, match;
  logic [TIME_BITS-1:0] incl_raw;
  logic [ACC_W-1:0] incl, self_t, par_sum;
  logic [CNT_W-1:0] e_calls;
  logic [ACC_W-1:0] e_incl, e_self;
  logic [LANG_W-1:0] e_lang;
  logic valid_now;
  logic [EN_W-1:0] ent_new;

  assign is_trace = (act == cstp_pkg::ACT_ENTER) || (act == cstp_pkg::ACT_EXIT);
  assign ign      = is_trace && !trace_enable;
  assign full     = (level >= LV_W'(STACK_DEPTH));
  assign empty    = (level == '0);
  assign do_push  = !ign && (act == cstp_pkg::ACT_ENTER);
  assign do_exit  = !ign && (act == cstp_pkg::ACT_EXIT);
  assign match    = (top_rd[FR_W-1 -: ID_W] == fid);
  assign incl_raw = ts - top_rd[TIME_BITS-1:0];

  // inclusive and self time
  always_comb begin
    incl = (TIME_BITS > ACC_W) ?
      ((|(incl_raw >> ACC_W)) ? MAX_ACC : ACC_W'(incl_raw)) : ACC_W'(incl_raw);
    self_t  = (incl > kids_rd) ? incl - kids_rd : '0;
    par_sum = (parent_rd >= MAX_ACC - incl) ? MAX_ACC : parent_rd + incl;
  end

  // updated entry
  always_comb begin
    valid_now = entry_valid[slot];
    if (valid_now) begin
      {e_calls, e_incl, e_self, e_lang} = ent_rd;
    end else begin
      e_calls = '0;
      e_incl  = '0;
      e_self  = '0;
      e_lang  = top_rd[TIME_BITS +: LANG_W];
    end
    ent_new = {((e_calls == MAX_CNT) ? MAX_CNT : e_calls + CNT_W'(1)),
               ((e_incl >= MAX_ACC - incl) ? MAX_ACC : e_incl + incl),
               ((e_self >= MAX_ACC - self_t) ? MAX_ACC : e_self + self_t),
               e_lang};
  end

  logic good_exit;
  assign good_exit = do_exit && !empty && match;

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.exec && do_push && !full) begin
      frame_mem[level[SA_W-1:0]] <= {fid, lang, ts};
      kids_mem[level[SA_W-1:0]]  <= '0;
    end else if (cmd.exec && good_exit && level > LV_W'(1)) begin
      kids_mem[par_a] <= par_sum;
    end
    if (cmd.exec && good_exit) entry_mem[slot] <= ent_new;
  end

  // result and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      level        <= '0;
      entry_valid  <= '0;
      enter_events <= '0;
      drop_events  <= '0;
      out_full     <= 1'b0;
    end else begin
      if (cmd.exec) begin
        status        <= cstp_pkg::ST_DONE;
        entry_present <= valid_now;
        {calls_total, inclusive_total, self_total, entry_language} <=
          valid_now ? ent_rd : '0;
        total_count   <= enter_events;
        dropped_count <= drop_events;
        priority if (ign) begin
          status <= cstp_pkg::ST_IGNORED;
        end else if (do_push) begin
          if (full) begin
            status <= cstp_pkg::ST_FULL;
            if (drop_events != MAX_CNT) drop_events <= drop_events + CNT_W'(1);
            dropped_count <= (drop_events != MAX_CNT) ? drop_events + CNT_W'(1) : MAX_CNT;
          end else begin
            level <= level + LV_W'(1);
            if (enter_events != MAX_CNT) enter_events <= enter_events + CNT_W'(1);
            total_count <= (enter_events != MAX_CNT) ? enter_events + CNT_W'(1) : MAX_CNT;
          end
        end else if (do_exit) begin
          if (!empty) level <= level - LV_W'(1);
          if (empty || !match) begin
            status <= cstp_pkg::ST_DROPPED;
            if (drop_events != MAX_CNT) drop_events <= drop_events + CNT_W'(1);
            dropped_count <= (drop_events != MAX_CNT) ? drop_events + CNT_W'(1) : MAX_CNT;
          end else begin
            entry_valid[slot] <= 1'b1;
            entry_present <= 1'b1;
            {calls_total, inclusive_total, self_total, entry_language} <= ent_new;
          end
        end else if (act == cstp_pkg::ACT_CLEAR_ALL) begin
          entry_valid   <= '0;
          enter_events  <= '0;
          drop_events   <= '0;
          total_count   <= '0;
          dropped_count <= '0;
          entry_present <= 1'b0;
          {calls_total, inclusive_total, self_total, entry_language} <= '0;
        end else if (act == cstp_pkg::ACT_READ_CLEAR) begin
          entry_valid[slot] <= 1'b0;
        end else if (act == cstp_pkg::ACT_CNT_CLEAR) begin
          enter_events <= '0;
          drop_events  <= '0;
        end else begin
          // plain read and the spare codes leave the state alone
        end
      end
      if (cmd.out_set) out_full <= 1'b1;
      else if (cmd.out_clr) out_full <= 1'b0;
    end
  end

  assign stack_level = cstp_pkg::LVL_W'(level);
  assign sts.out_full = out_full;

endmodule
